// ===== hw/rtl/ctd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ctd_pkg;

    localparam int SIZE_BITS_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_SP  = 8'h20;
    localparam logic [7:0] BYTE_TAB = 8'h09;

    localparam logic [1:0] STAT_RUN  = 2'd0;
    localparam logic [1:0] STAT_DONE = 2'd1;
    localparam logic [1:0] STAT_ERR  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_message;
    } t_in_item;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       chunk_end;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_message;
        logic       is_lf;
        logic       is_cr;
        logic       is_ws;
        logic       is_hex;
        logic [3:0] hex_val;
    } t_class_item;

    typedef enum logic [8:0] {
        ST_LEAD   = 9'b000000001,
        ST_DIGITS = 9'b000000010,
        ST_SKIP   = 9'b000000100,
        ST_DATA   = 9'b000001000,
        ST_CR     = 9'b000010000,
        ST_LF     = 9'b000100000,
        ST_TRAIL  = 9'b001000000,
        ST_DONE   = 9'b010000000,
        ST_ERROR  = 9'b100000000
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/ctd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctd_front
    import ctd_pkg::*;
(
    input  wire t_in_item    i_item,
    output t_class_item      o_item
);

    logic [7:0] b;

    assign b = i_item.data_byte;

    always_comb begin
        o_item             = '0;
        o_item.data_byte   = b;
        o_item.new_message = i_item.new_message;
        o_item.is_lf       = (b == BYTE_LF);
        o_item.is_cr       = (b == BYTE_CR);
        o_item.is_ws       = (b == BYTE_SP) || (b == BYTE_TAB);
        if (b >= 8'h30 && b <= 8'h39) begin
            o_item.is_hex  = 1'b1;
            o_item.hex_val = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            o_item.is_hex  = 1'b1;
            o_item.hex_val = b[3:0] + 4'd9;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ctd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ctd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctd_back
    import ctd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire t_class_item i_item,
    input  wire         i_item_valid,
    output logic        o_item_take,
    output t_out_item   o_out,
    output logic        o_out_valid,
    input  wire         i_out_pop
);

    t_state                r_st, n_st, cur_st;
    logic [SIZE_BITS-1:0]  r_rem, n_rem, dec_rem;
    logic [SIZE_BITS-1:0]  r_acc, n_acc, cur_acc;
    logic [1:0]            r_lchars, n_lchars, cur_lchars;
    logic                  r_fcr, n_fcr, cur_fcr;
    t_out_item             r_out, n_out;
    logic                  r_out_valid;
    logic                  slot_free;

    assign slot_free   = !r_out_valid || i_out_pop;
    assign o_item_take = i_item_valid && slot_free;
    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;
    assign dec_rem     = r_rem - 1'b1;

    always_comb begin
        cur_st     = i_item.new_message ? ST_LEAD : r_st;
        cur_acc    = i_item.new_message ? '0 : r_acc;
        cur_lchars = i_item.new_message ? 2'd0 : r_lchars;
        cur_fcr    = i_item.new_message ? 1'b0 : r_fcr;

        n_st     = cur_st;
        n_acc    = cur_acc;
        n_lchars = cur_lchars;
        n_fcr    = cur_fcr;
        n_rem    = i_item.new_message ? '0 : r_rem;
        n_out    = '0;
        n_out.status = STAT_RUN;

        unique case (cur_st)
            ST_LEAD, ST_DIGITS, ST_SKIP: begin
                if (i_item.is_lf) begin
                    if (cur_acc == '0) begin
                        n_st     = ST_TRAIL;
                        n_lchars = 2'd0;
                        n_fcr    = 1'b0;
                    end else begin
                        n_rem = cur_acc;
                        n_acc = '0;
                        n_st  = ST_DATA;
                    end
                end else if (cur_st == ST_SKIP) begin
                    n_st = ST_SKIP;
                end else if (i_item.is_hex) begin
                    if (|cur_acc[SIZE_BITS-1:SIZE_BITS-4]) begin
                        n_acc = '1;
                    end else begin
                        n_acc = {cur_acc[SIZE_BITS-5:0], i_item.hex_val};
                    end
                    n_st = ST_DIGITS;
                end else if (cur_st == ST_LEAD && i_item.is_ws) begin
                    n_st = ST_LEAD;
                end else begin
                    n_st = ST_SKIP;
                end
            end
            ST_DATA: begin
                n_out.payload_valid = 1'b1;
                n_out.payload_byte  = i_item.data_byte;
                n_rem               = dec_rem;
                if (dec_rem == '0) begin
                    n_out.chunk_end = 1'b1;
                    n_st            = ST_CR;
                end
            end
            ST_CR: begin
                if (i_item.is_cr) begin
                    n_st = ST_LF;
                end else begin
                    n_st         = ST_ERROR;
                    n_out.status = STAT_ERR;
                end
            end
            ST_LF: begin
                if (i_item.is_lf) begin
                    n_st  = ST_LEAD;
                    n_acc = '0;
                end else begin
                    n_st         = ST_ERROR;
                    n_out.status = STAT_ERR;
                end
            end
            ST_TRAIL: begin
                if (i_item.is_lf) begin
                    if (cur_lchars == 2'd0 || (cur_lchars == 2'd1 && cur_fcr)) begin
                        n_st         = ST_DONE;
                        n_out.status = STAT_DONE;
                    end
                    n_lchars = 2'd0;
                    n_fcr    = 1'b0;
                end else begin
                    if (cur_lchars == 2'd0) begin
                        n_fcr = i_item.is_cr;
                    end
                    if (cur_lchars != 2'd2) begin
                        n_lchars = cur_lchars + 2'd1;
                    end
                end
            end
            ST_DONE: begin
                n_out.status = STAT_DONE;
            end
            default: begin
                n_st         = ST_ERROR;
                n_out.status = STAT_ERR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_LEAD;
            r_rem       <= '0;
            r_acc       <= '0;
            r_lchars    <= 2'd0;
            r_fcr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_item_take) begin
                r_st        <= n_st;
                r_rem       <= n_rem;
                r_acc       <= n_acc;
                r_lchars    <= n_lchars;
                r_fcr       <= n_fcr;
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st))
        else $error("state register not one-hot");

    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DATA) |-> (r_rem != '0))
        else $error("data phase with no bytes due");

    a_end_on_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.chunk_end) |-> r_out.payload_valid)
        else $error("chunk end without payload");

    a_data_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.payload_valid) |-> (r_out.status == STAT_RUN))
        else $error("payload with final status");

    a_end_to_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_item_take && n_out.chunk_end) |=> (r_st == ST_CR))
        else $error("chunk end did not move to CR check");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/chunked_transfer_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Decodes an HTTP chunked body one byte per transfer and gives exactly one
// result per byte: the payload byte with its chunk-end flag, or a status of
// in progress, done or framing error. A byte is accepted every cycle unless
// full is high; the back end's state update sets that rate. A byte pushed
// into an empty block is queued, then registered in the back end's output
// register; the queue (QUEUE_DEPTH bytes) lets push run on while pop stalls.
// Raise new_message on the first byte of each message to clear the decoder.

module chunked_transfer_decoder
    import ctd_pkg::*;
#(
    parameter int SIZE_BITS   = SIZE_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       push,
    output logic      full,
    input  wire t_in_item i_in_item,
    output logic      empty,
    input  wire       pop,
    output t_out_item o_out_item
);

    t_class_item cls_item;
    t_class_item q_item;
    logic        q_empty;
    logic        q_take;
    logic        out_valid;

    ctd_front u_front (
        .i_item (i_in_item),
        .o_item (cls_item)
    );

    ctd_queue #(
        .WIDTH ($bits(t_class_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_item),
        .o_full  (full),
        .i_pop   (q_take),
        .o_data  (q_item),
        .o_empty (q_empty)
    );

    ctd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_item_valid (!q_empty),
        .o_item_take  (q_take),
        .o_out        (o_out_item),
        .o_out_valid  (out_valid),
        .i_out_pop    (pop)
    );

    assign empty = !out_valid;

endmodule

`default_nettype wire

// ===== sim/ctd_checker.sv =====
`timescale 1ns / 1ps

module ctd_checker
    import ctd_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_push,
    input  wire       i_full,
    input  t_in_item  i_in_item,
    input  wire       i_empty,
    input  wire       i_pop,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_payload_count,
    output int        o_done_count,
    output int        o_error_count
);

    localparam int SZ = SIZE_BITS_DEF;
    localparam logic [SZ-1:0] SIZE_FULL = '1;

    t_state        dec_state      = ST_LEAD;
    logic [SZ-1:0] bytes_left     = '0;
    logic [SZ-1:0] size_value     = '0;
    logic [1:0]    trail_len      = '0;
    logic          trail_cr_first = 1'b0;

    t_out_item expected_q[$];

    int fail_count    = 0;
    int pending       = 0;
    int payload_count = 0;
    int done_count    = 0;
    int error_count   = 0;

    assign o_fail_count    = fail_count;
    assign o_pending       = pending;
    assign o_payload_count = payload_count;
    assign o_done_count    = done_count;
    assign o_error_count   = error_count;

    function automatic void clear_decoder();
        dec_state      = ST_LEAD;
        bytes_left     = '0;
        size_value     = '0;
        trail_len      = '0;
        trail_cr_first = 1'b0;
    endfunction

    function automatic void finish_size_line();
        if (size_value == '0) begin
            dec_state      = ST_TRAIL;
            trail_len      = '0;
            trail_cr_first = 1'b0;
        end else begin
            bytes_left = size_value;
            size_value = '0;
            dec_state  = ST_DATA;
        end
    endfunction

    function automatic t_out_item decode_byte(t_in_item item);
        t_out_item  res;
        logic [7:0] b;
        logic       is_hex;
        logic [3:0] nib;
        b      = item.data_byte;
        res    = '0;
        is_hex = 1'b1;
        nib    = '0;
        if (item.new_message) begin
            clear_decoder();
        end
        if (b >= 8'h30 && b <= 8'h39) begin
            nib = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            nib = b[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
        res.status = STAT_RUN;
        case (dec_state)
            ST_LEAD, ST_DIGITS: begin
                if (b == BYTE_LF) begin
                    finish_size_line();
                end else if (is_hex) begin
                    if (size_value > (SIZE_FULL >> 4)) begin
                        size_value = SIZE_FULL;
                    end else begin
                        size_value = {size_value[SZ-5:0], nib};
                    end
                    dec_state = ST_DIGITS;
                end else if (!(dec_state == ST_LEAD && (b == BYTE_SP || b == BYTE_TAB))) begin
                    dec_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (b == BYTE_LF) begin
                    finish_size_line();
                end
            end
            ST_DATA: begin
                res.payload_valid = 1'b1;
                res.payload_byte  = b;
                bytes_left        = bytes_left - 1'b1;
                if (bytes_left == '0) begin
                    res.chunk_end = 1'b1;
                    dec_state     = ST_CR;
                end
            end
            ST_CR: begin
                if (b == BYTE_CR) begin
                    dec_state = ST_LF;
                end else begin
                    dec_state  = ST_ERROR;
                    res.status = STAT_ERR;
                end
            end
            ST_LF: begin
                if (b == BYTE_LF) begin
                    dec_state  = ST_LEAD;
                    size_value = '0;
                end else begin
                    dec_state  = ST_ERROR;
                    res.status = STAT_ERR;
                end
            end
            ST_TRAIL: begin
                if (b == BYTE_LF) begin
                    if (trail_len == 2'd0 || (trail_len == 2'd1 && trail_cr_first)) begin
                        dec_state  = ST_DONE;
                        res.status = STAT_DONE;
                    end
                    trail_len      = '0;
                    trail_cr_first = 1'b0;
                end else begin
                    if (trail_len == 2'd0) begin
                        trail_cr_first = (b == BYTE_CR);
                    end
                    if (trail_len != 2'd2) begin
                        trail_len = trail_len + 2'd1;
                    end
                end
            end
            ST_DONE: begin
                res.status = STAT_DONE;
            end
            default: begin
                dec_state  = ST_ERROR;
                res.status = STAT_ERR;
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_decoder();
            expected_q.delete();
            pending = 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (i_out_item.payload_valid === 1'b1) payload_count++;
                if (i_out_item.status === STAT_DONE) done_count++;
                if (i_out_item.status === STAT_ERR) error_count++;
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result at %0t: valid %0b byte %02h end %0b status %0d",
                                 $time, i_out_item.payload_valid, i_out_item.payload_byte,
                                 i_out_item.chunk_end, i_out_item.status);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (want.payload_valid !== i_out_item.payload_valid ||
                        want.payload_byte !== i_out_item.payload_byte ||
                        want.chunk_end !== i_out_item.chunk_end ||
                        want.status !== i_out_item.status) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch at %0t: expected valid %0b byte %02h end %0b status %0d",
                                     $time, want.payload_valid, want.payload_byte,
                                     want.chunk_end, want.status);
                            $display("    got valid %0b byte %02h end %0b status %0d",
                                     i_out_item.payload_valid, i_out_item.payload_byte,
                                     i_out_item.chunk_end, i_out_item.status);
                        end
                    end
                end
            end
            if (i_push && !i_full) begin
                expected_q.push_back(decode_byte(i_in_item));
            end
            pending = expected_q.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ctd_pkg::*;

    localparam int N_ITEMS    = 1000;
    localparam int LIMIT      = 200000;
    localparam int CALM_FROM  = 250;
    localparam int CALM_TO    = 450;
    localparam int HOLD_AT    = 600;
    localparam int HOLD_LEN   = 80;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  in_item = '0;
    logic      full;
    logic      empty;
    t_out_item out_item;

    int fail_count;
    int pending;
    int payload_count;
    int done_count;
    int error_count;

    t_in_item body_q[$];
    bit       msg_start   = 1'b0;
    bit       tail_mode   = 1'b0;
    int       live_bytes  = 0;
    int       msg_count   = 0;
    int       sent_count  = 0;
    int       cycle_count = 0;

    always #2 i_clk = ~i_clk;

    chunked_transfer_decoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_item)
    );

    ctd_checker decode_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_in_item       (in_item),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_out_item      (out_item),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_payload_count (payload_count),
        .o_done_count    (done_count),
        .o_error_count   (error_count)
    );

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic logic [3:0] rand_nib(int unsigned lo, int unsigned hi);
        return 4'($urandom_range(lo, hi));
    endfunction

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        b = rand_byte();
        return (b == BYTE_LF) ? 8'h78 : b;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10) return 8'h30 + v;
        return (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    function automatic bit in_calm_stretch();
        return sent_count >= CALM_FROM && sent_count < CALM_TO;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        t_in_item item;
        item.data_byte   = b;
        item.new_message = msg_start;
        msg_start        = 1'b0;
        body_q.push_back(item);
        if (!tail_mode) live_bytes++;
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            put_byte(s[i]);
        end
    endfunction

    function automatic void put_size_line(logic [31:0] size);
        bit         seen;
        logic [3:0] nib;
        seen = 1'b0;
        repeat ($urandom_range(0, 2)) put_byte(($urandom_range(0, 1) == 1) ? BYTE_SP : BYTE_TAB);
        if ($urandom_range(0, 9) == 0) put_byte(hex_char(4'd0));
        for (int i = 7; i >= 0; i--) begin
            nib = size[i*4 +: 4];
            if (nib != 4'd0 || seen || i == 0) begin
                seen = 1'b1;
                put_byte(hex_char(nib));
            end
        end
        if ($urandom_range(0, 4) == 0) begin
            put_text(";");
            repeat ($urandom_range(0, 4)) put_byte(any_but_lf());
        end
        if ($urandom_range(0, 3) != 0) put_byte(BYTE_CR);
        put_byte(BYTE_LF);
    endfunction

    task automatic build_directed();
        msg_start = 1'b1;
        put_text(" \t2");
        put_byte(BYTE_LF);
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(BYTE_CR);
        put_byte(BYTE_LF);
        put_text("0");
        put_byte(BYTE_LF);
        put_byte(BYTE_CR);
        put_byte(BYTE_LF);
        put_text("x");
        msg_start = 1'b1;
        put_text("g");
        put_byte(BYTE_LF);
        put_text("a");
        put_byte(BYTE_LF);
        put_byte(BYTE_LF);
        msg_start = 1'b1;
        put_text("1");
        put_byte(BYTE_LF);
        put_text("zqy");
    endtask

    task automatic build_random();
        int unsigned len;
        msg_count++;
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 8)) begin
                msg_start = ($urandom_range(0, 1) == 1);
                put_byte(rand_byte());
            end
            return;
        end
        msg_start = 1'b1;
        // saturate the size, then abandon the chunk
        if (msg_count % 16 == 3) begin
            repeat ($urandom_range(0, 1)) put_byte(BYTE_SP);
            put_byte(hex_char(rand_nib(1, 15)));
            repeat ($urandom_range(8, 10)) put_byte(hex_char(rand_nib(0, 15)));
            put_byte(BYTE_LF);
            repeat ($urandom_range(1, 6)) put_byte(rand_byte());
            return;
        end
        repeat ($urandom_range(0, 3)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            put_size_line(len);
            repeat (len) put_byte(rand_byte());
            if ($urandom_range(0, 29) == 0) begin
                put_byte(rand_byte());
                return;
            end
            put_byte(BYTE_CR);
            if ($urandom_range(0, 29) == 0) begin
                put_byte(rand_byte());
                return;
            end
            put_byte(BYTE_LF);
        end
        case ($urandom_range(0, 5))
            0: begin
                put_text("x;z");
                put_byte(BYTE_CR);
                put_byte(BYTE_LF);
            end
            1: begin
                put_text("0x1a");
                put_byte(BYTE_CR);
                put_byte(BYTE_LF);
            end
            default: begin
                put_size_line(0);
            end
        endcase
        repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(1, 5)) put_byte(any_but_lf());
            if ($urandom_range(0, 1) == 1) put_byte(BYTE_CR);
            put_byte(BYTE_LF);
        end
        if ($urandom_range(0, 1) == 1) put_byte(BYTE_CR);
        put_byte(BYTE_LF);
        tail_mode = 1'b1;
        repeat ($urandom_range(0, 2)) put_byte(rand_byte());
        tail_mode = 1'b0;
    endtask

    task automatic send_byte(t_in_item item);
        while (!in_calm_stretch() && $urandom_range(0, 99) < 20) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        in_item <= item;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sent_count++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench failed");
            $finish;
        end
    end

    initial begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (in_calm_stretch()) begin
                pop <= 1'b1;
            end else begin
                pop <= ($urandom_range(0, 99) >= 20);
            end
        end
    end

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        build_directed();
        while (live_bytes < N_ITEMS) build_random();
        while (body_q.size() > 0) send_byte(body_q.pop_front());
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        $display("sent %0d bytes in %0d messages with a %0d-cycle receive stall",
                 sent_count, msg_count, HOLD_LEN);
        $display("checked %0d payload bytes, %0d done and %0d error results",
                 payload_count, done_count, error_count);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ctd_pkg.sv
hw/rtl/ctd_front.sv
hw/rtl/ctd_queue.sv
hw/rtl/ctd_back.sv
hw/rtl/chunked_transfer_decoder.sv
sim/ctd_checker.sv
sim/testbench.sv
